// ----- rtl/odvr_pkg.sv -----
`default_nettype none
package odvr_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_REMOVE,
    CMD_NOP
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/odvr_if.sv -----
`default_nettype none
interface odvr_in_if;
  import odvr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface odvr_out_if;
  import odvr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, status, count, front_value, back_value, input ready);
  modport sink   (input valid, status, count, front_value, back_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/odvr_front.sv -----
`default_nettype none
module odvr_front (
  odvr_in_if.sink         item,
  output logic            push_valid,
  input  logic            push_ready,
  output odvr_pkg::cmd_t  push_cmd
);
  import odvr_pkg::*;

  assign item.ready = push_ready;
  assign push_valid = item.valid;

  always_comb begin
    push_cmd.value = item.value;
    unique case (op_t'(item.op))
      OP_PUSH_FRONT: push_cmd.kind = CMD_PUSH_FRONT;
      OP_PUSH_BACK:  push_cmd.kind = CMD_PUSH_BACK;
      OP_REMOVE:     push_cmd.kind = CMD_REMOVE;
      default:       push_cmd.kind = CMD_NOP;   // unused code: report not found
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/odvr_queue.sv -----
`default_nettype none
module odvr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  odvr_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output odvr_pkg::cmd_t  pop_cmd
);
  import odvr_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/odvr_back.sv -----
`default_nettype none
module odvr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  odvr_pkg::cmd_t  cmd,
  odvr_out_if.source      result
);
  import odvr_pkg::*;

  // entries kept in logical order: slot 0 is the front
  logic signed [DATA_W-1:0] ent      [CAPACITY];
  logic signed [DATA_W-1:0] ent_next [CAPACITY];
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;

  logic                     res_valid;
  status_t                  res_status;
  logic [CNT_W-1:0]         res_count;
  logic signed [DATA_W-1:0] res_front;
  logic signed [DATA_W-1:0] res_back;

  status_t                  status_next;
  logic signed [DATA_W-1:0] front_next;
  logic signed [DATA_W-1:0] back_next;
  logic                     hit;
  logic [IDX_W-1:0]         k;
  logic                     full;
  logic                     take;

  assign cmd_ready = !res_valid || result.ready;
  assign take      = cmd_valid && cmd_ready;
  assign full      = (cnt == CNT_W'(CAPACITY));

  always_comb begin
    hit = 1'b0;
    k   = '0;
    // scan from the back so the lowest matching slot wins
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt) && (ent[i] == cmd.value)) begin
        hit = 1'b1;
        k   = IDX_W'(i);
      end
    end

    ent_next    = ent;
    cnt_next    = cnt;
    status_next = ST_NOT_FOUND;

    unique case (cmd.kind)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ent_next[0] = cmd.value;
          for (int i = 1; i < CAPACITY; i++) begin
            ent_next[i] = ent[i-1];
          end
          cnt_next    = cnt + CNT_W'(1);
          status_next = ST_INSERTED;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == cnt) begin
              ent_next[i] = cmd.value;
            end
          end
          cnt_next    = cnt + CNT_W'(1);
          status_next = ST_INSERTED;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= k) begin
              ent_next[i] = ent[i+1];
            end
          end
          cnt_next    = cnt - CNT_W'(1);
          status_next = ST_REMOVED;
        end
      end
      CMD_NOP: begin
        status_next = ST_NOT_FOUND;
      end
    endcase

    if (cnt_next == '0) begin
      front_next = '0;
      back_next  = '0;
    end else begin
      front_next = ent_next[0];
      back_next  = ent_next[IDX_W'(cnt_next - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent        <= ent_next;
      res_status <= status_next;
      res_count  <= cnt_next;
      res_front  <= front_next;
      res_back   <= back_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        cnt       <= cnt_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.status      = res_status;
  assign result.count       = res_count;
  assign result.front_value = res_front;
  assign result.back_value  = res_back;

endmodule
`default_nettype wire

// ----- rtl/ordered_deque_with_value_removal_core.sv -----
`default_nettype none
// Ordered deque of up to CAPACITY signed 32-bit values with insert at front,
// insert at back and removal of the first match searched from the front. Each
// item beat gives exactly one result beat carrying status, count and the
// front and back values (zero when empty). Sustained rate is one item per
// cycle while the output is not stalled; an accepted item is first held in
// the two-entry command queue, then the execute stage compares all entries
// in parallel, shifts the register array and registers the result, which is
// then presented. The queue and the output register let input and output
// stall independently.
module ordered_deque_with_value_removal_core (
  input  logic       clk,
  input  logic       rst,
  odvr_in_if.sink    item,
  odvr_out_if.source result
);
  import odvr_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  odvr_front u_front (
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  odvr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  odvr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .result    (result)
  );

endmodule
`default_nettype wire

// ----- rtl/odvr_checker.sv -----
`default_nettype none
module odvr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             result_valid,
  input logic                             result_ready,
  input logic [1:0]                       status,
  input logic [odvr_pkg::CNT_W-1:0]       count,
  input logic signed [odvr_pkg::DATA_W-1:0] front_value,
  input logic signed [odvr_pkg::DATA_W-1:0] back_value
);
  import odvr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable({status, count, front_value, back_value}))
    else $error("result beat changed while stalled");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_FULL) |-> count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_inserted: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_INSERTED) |-> count != '0)
    else $error("insert left the store empty");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (count == '0) |-> (front_value == '0) && (back_value == '0))
    else $error("empty store shows nonzero ends");

endmodule

bind ordered_deque_with_value_removal_core odvr_checker u_odvr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.status),
  .count        (result.count),
  .front_value  (result.front_value),
  .back_value   (result.back_value)
);
`default_nettype wire
